### src/ds_twr_distance_unit_defines.svh
// assertion macros shared by the ranging block
`ifndef DS_TWR_DISTANCE_UNIT_DEFINES_SVH
`define DS_TWR_DISTANCE_UNIT_DEFINES_SVH

// same-cycle implication
`define DSTWR_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ds_twr_distance_unit check failed");

// next-cycle implication
`define DSTWR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ds_twr_distance_unit check failed");

`endif

### src/dstwr_pkg.sv
package dstwr_pkg;

   localparam int STAMP_IN_BITS   = 32;
   localparam int SCALE_FRAC_BITS = 16;
   localparam int QUOT_BITS       = 64;
   localparam int QHALF_BITS      = QUOT_BITS / 2;
   localparam int DIST_BITS       = 16;
   localparam int STATUS_BITS     = 2;
   localparam int REQ_TDATA_BITS  = 5 * STAMP_IN_BITS;
   localparam int RSP_TDATA_BITS  = 24;

   localparam logic [SCALE_FRAC_BITS-1:0] SCALE_RESET = 16'd30739;

   localparam logic [DIST_BITS-1:0] FAIL_CODE    = 16'd65535;
   localparam logic [DIST_BITS-1:0] MAX_GOOD_CM  = 16'd65534;
   localparam logic [DIST_BITS-1:0] NEG_LIMIT_CM = 16'd100;

   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_CLAMPED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FAILED  = 2'd2;

   typedef struct packed {
      logic neg;
      logic den_zero;
   } dstwr_side_type;

endpackage

### src/dstwr_divider.sv
module dstwr_divider import dstwr_pkg::*; #(
   parameter int NUM_BITS = 80,
   parameter int DEN_BITS = 34
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [NUM_BITS-1:0] in_num,
   input  logic [DEN_BITS-1:0] in_den,
   input  dstwr_side_type      in_side,
   output logic                out_valid,
   output logic [NUM_BITS-1:0] out_quo,
   output dstwr_side_type      out_side
);

   // one quotient bit per stage; numerator bits shift out as quotient bits shift in
   logic [NUM_BITS-1:0] valid_ff;
   logic [NUM_BITS-1:0] valid_in;
   logic [NUM_BITS-1:0] nq_ff   [NUM_BITS];
   logic [NUM_BITS-1:0] nq_in   [NUM_BITS];
   logic [DEN_BITS-1:0] rem_ff  [NUM_BITS];
   logic [DEN_BITS-1:0] rem_in  [NUM_BITS];
   logic [DEN_BITS-1:0] den_ff  [NUM_BITS];
   logic [DEN_BITS-1:0] den_in  [NUM_BITS];
   dstwr_side_type      side_ff [NUM_BITS];
   dstwr_side_type      side_in [NUM_BITS];

   logic                src_valid [NUM_BITS];
   logic [NUM_BITS-1:0] src_nq    [NUM_BITS];
   logic [DEN_BITS-1:0] src_rem   [NUM_BITS];
   logic [DEN_BITS-1:0] src_den   [NUM_BITS];
   dstwr_side_type      src_side  [NUM_BITS];
   logic [DEN_BITS:0]   trial     [NUM_BITS];
   logic [DEN_BITS:0]   diff      [NUM_BITS];
   logic                fits      [NUM_BITS];

   for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign src_valid[s] = in_valid;
         assign src_nq[s]    = in_num;
         assign src_rem[s]   = '0;
         assign src_den[s]   = in_den;
         assign src_side[s]  = in_side;
      end else begin : g_next
         assign src_valid[s] = valid_ff[s-1];
         assign src_nq[s]    = nq_ff[s-1];
         assign src_rem[s]   = rem_ff[s-1];
         assign src_den[s]   = den_ff[s-1];
         assign src_side[s]  = side_ff[s-1];
      end
      assign trial[s]    = {src_rem[s], src_nq[s][NUM_BITS-1]};
      assign diff[s]     = trial[s] - {1'b0, src_den[s]};
      assign fits[s]     = trial[s] >= {1'b0, src_den[s]};
      assign rem_in[s]   = fits[s] ? diff[s][DEN_BITS-1:0] : trial[s][DEN_BITS-1:0];
      assign nq_in[s]    = {src_nq[s][NUM_BITS-2:0], fits[s]};
      assign valid_in[s] = src_valid[s];
      assign den_in[s]   = src_den[s];
      assign side_in[s]  = src_side[s];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < NUM_BITS; s++) begin
            nq_ff[s]   <= nq_in[s];
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= den_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign out_valid = valid_ff[NUM_BITS-1];
   assign out_quo   = nq_ff[NUM_BITS-1];
   assign out_side  = side_ff[NUM_BITS-1];

endmodule

### src/ds_twr_distance_unit.sv
// pipeline: a req beat passes the a, b and c registers, the divider stages, then d, e and the rsp register
// throughput: one beat per cycle while no rsp beat is stalled; the divider resolves one quotient bit per pipeline stage
// a stalled rsp beat holds every stage and drops req_tready
// reset: synchronous, active high; clears all valid bits and loads the scale with 30739
`include "ds_twr_distance_unit_defines.svh"

module ds_twr_distance_unit import dstwr_pkg::*; #(
   parameter int STAMP_BITS    = 32,
   parameter int TOF_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [SCALE_FRAC_BITS-1:0] csr_wr_data,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // poll_receive_time, response_send_time, final_receive_time, initiator_round,
   // initiator_reply
   input  logic [REQ_TDATA_BITS-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // distance_cm, range_status, zero pad
   output logic [RSP_TDATA_BITS-1:0]  rsp_tdata
);

   localparam int W     = STAMP_BITS;
   localparam int PW    = 2 * STAMP_BITS;
   localparam int DW    = STAMP_BITS + 2;
   localparam int NB    = PW + TOF_FRAC_BITS;
   localparam int SH    = SCALE_FRAC_BITS + TOF_FRAC_BITS;
   localparam int PRW   = QHALF_BITS + SCALE_FRAC_BITS;
   localparam int SUMW  = QUOT_BITS + SCALE_FRAC_BITS;
   localparam int CMW   = SUMW - SH;
   localparam int PAD   = RSP_TDATA_BITS - DIST_BITS - STATUS_BITS;
   localparam logic [SUMW-1:0] HALF = SUMW'(1) << (SH - 1);

   logic advance;

   logic [SCALE_FRAC_BITS-1:0] scale_ff;

   logic [W-1:0] poll_ext, resp_ext, fin_ext;
   logic         a_valid_ff;
   logic [W-1:0] a_ra_ff, a_ra_in, a_da_ff, a_da_in, a_rb_ff, a_rb_in, a_db_ff, a_db_in;

   logic          b_valid_ff;
   logic [PW-1:0] b_p1_ff, b_p1_in, b_p2_ff, b_p2_in;
   logic [DW-1:0] b_den_ff, b_den_in;

   logic           c_valid_ff;
   logic [PW:0]    c_d12, c_d21;
   logic [PW-1:0]  c_mag_ff, c_mag_in;
   logic [DW-1:0]  c_den_ff;
   dstwr_side_type c_side_ff, c_side_in;

   logic           q_valid;
   logic [NB-1:0]  q_quo;
   dstwr_side_type q_side;
   logic [QUOT_BITS-1:0] q_low;
   logic           q_big;

   logic           d_valid_ff;
   logic [PRW-1:0] d_lo_ff, d_lo_in, d_hi_ff, d_hi_in;
   logic           d_fail_ff, d_neg_ff;

   logic            e_valid_ff;
   logic [SUMW-1:0] e_sum_ff, e_sum_in;
   logic            e_fail_ff, e_neg_ff;
   logic [CMW-1:0]  e_cm;

   logic                   rsp_tvalid_ff;
   logic [DIST_BITS-1:0]   rsp_dist_ff, rsp_dist_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;

   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   // timestamp differences
   assign poll_ext = W'(req_tdata[STAMP_IN_BITS-1:0]);
   assign resp_ext = W'(req_tdata[2*STAMP_IN_BITS-1:STAMP_IN_BITS]);
   assign fin_ext  = W'(req_tdata[3*STAMP_IN_BITS-1:2*STAMP_IN_BITS]);
   assign a_ra_in  = W'(req_tdata[4*STAMP_IN_BITS-1:3*STAMP_IN_BITS]);
   assign a_da_in  = W'(req_tdata[5*STAMP_IN_BITS-1:4*STAMP_IN_BITS]);
   assign a_rb_in  = fin_ext - resp_ext;
   assign a_db_in  = resp_ext - poll_ext;

   // products and denominator
   assign b_p1_in  = PW'(a_ra_ff) * PW'(a_rb_ff);
   assign b_p2_in  = PW'(a_da_ff) * PW'(a_db_ff);
   assign b_den_in = DW'(a_ra_ff) + DW'(a_rb_ff) + DW'(a_da_ff) + DW'(a_db_ff);

   // magnitude and sign of the numerator, and a zero-denominator flag
   assign c_d12              = {1'b0, b_p1_ff} - {1'b0, b_p2_ff};
   assign c_d21              = {1'b0, b_p2_ff} - {1'b0, b_p1_ff};
   assign c_side_in.neg      = c_d12[PW];
   assign c_side_in.den_zero = (b_den_ff == '0);
   assign c_mag_in           = c_d12[PW] ? c_d21[PW-1:0] : c_d12[PW-1:0];

   dstwr_divider #(
      .NUM_BITS (NB),
      .DEN_BITS (DW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (c_valid_ff),
      .in_num    ({c_mag_ff, {TOF_FRAC_BITS{1'b0}}}),
      .in_den    (c_den_ff),
      .in_side   (c_side_ff),
      .out_valid (q_valid),
      .out_quo   (q_quo),
      .out_side  (q_side)
   );

   assign q_low = QUOT_BITS'(q_quo);
   if (NB > QUOT_BITS) begin : g_big
      assign q_big = |q_quo[NB-1:QUOT_BITS];
   end else begin : g_no_big
      assign q_big = 1'b0;
   end

   // quotient split into two half-width partial products with the scale
   assign d_lo_in = PRW'(q_low[QHALF_BITS-1:0]) * PRW'(scale_ff);
   assign d_hi_in = PRW'(q_low[QUOT_BITS-1:QHALF_BITS]) * PRW'(scale_ff);

   assign e_sum_in = {d_hi_ff, {QHALF_BITS{1'b0}}} + SUMW'(d_lo_ff) + HALF;

   // rounding result and range check
   assign e_cm = e_sum_ff[SUMW-1:SH];

   always_comb begin
      rsp_dist_in   = FAIL_CODE;
      rsp_status_in = STATUS_FAILED;
      priority if (e_fail_ff) begin
         rsp_dist_in   = FAIL_CODE;
         rsp_status_in = STATUS_FAILED;
      end else if (!e_neg_ff) begin
         if (e_cm <= CMW'(MAX_GOOD_CM)) begin
            rsp_dist_in   = e_cm[DIST_BITS-1:0];
            rsp_status_in = STATUS_OK;
         end
      end else begin
         if (e_cm < CMW'(NEG_LIMIT_CM)) begin
            rsp_dist_in   = '0;
            rsp_status_in = (e_cm == '0) ? STATUS_OK : STATUS_CLAMPED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         c_valid_ff    <= 1'b0;
         d_valid_ff    <= 1'b0;
         e_valid_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff    <= req_tvalid;
         b_valid_ff    <= a_valid_ff;
         c_valid_ff    <= b_valid_ff;
         d_valid_ff    <= q_valid;
         e_valid_ff    <= d_valid_ff;
         rsp_tvalid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ra_ff       <= a_ra_in;
         a_da_ff       <= a_da_in;
         a_rb_ff       <= a_rb_in;
         a_db_ff       <= a_db_in;
         b_p1_ff       <= b_p1_in;
         b_p2_ff       <= b_p2_in;
         b_den_ff      <= b_den_in;
         c_mag_ff      <= c_mag_in;
         c_den_ff      <= b_den_ff;
         c_side_ff     <= c_side_in;
         d_lo_ff       <= d_lo_in;
         d_hi_ff       <= d_hi_in;
         d_fail_ff     <= q_side.den_zero || q_big;
         d_neg_ff      <= q_side.neg;
         e_sum_ff      <= e_sum_in;
         e_fail_ff     <= d_fail_ff;
         e_neg_ff      <= d_neg_ff;
         rsp_dist_ff   <= rsp_dist_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{PAD{1'b0}}, rsp_status_ff, rsp_dist_ff};

   `DSTWR_ASSERT_HOLDS(a_stall_blocks_req, clock, reset, rsp_tvalid_ff && !rsp_tready, !req_tready)
   `DSTWR_ASSERT_HOLDS(a_clamp_zero, clock, reset, rsp_tvalid_ff && rsp_status_ff == STATUS_CLAMPED, rsp_dist_ff == '0)
   `DSTWR_ASSERT_HOLDS(a_fail_code, clock, reset, rsp_tvalid_ff && rsp_status_ff == STATUS_FAILED, rsp_dist_ff == FAIL_CODE)
   `DSTWR_ASSERT_NEXT(a_scale_write, clock, reset, csr_wr_en, scale_ff == $past(csr_wr_data))

endmodule
